FILE: hw/rtl/ttip_pkg.sv
package ttip_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_OFFSET = 1023;
  localparam int OFFSET_W   = 10;
  localparam int RADIX_W    = 6;
  localparam int DIGIT_W    = 7;

  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_UP_A     = 8'h41;
  localparam logic [7:0] CH_UP_X     = 8'h58;
  localparam logic [7:0] CH_UP_Z     = 8'h5A;
  localparam logic [7:0] CH_LO_A     = 8'h61;
  localparam logic [7:0] CH_LO_X     = 8'h78;
  localparam logic [7:0] CH_LO_Z     = 8'h7A;
  localparam logic [7:0] UP_BIAS     = CH_UP_A - 8'd10;
  localparam logic [7:0] LO_BIAS     = CH_LO_A - 8'd10;
  localparam logic [DIGIT_W-1:0] NO_DIGIT = 7'd64;

  localparam logic [RADIX_W-1:0] BASE_OCT = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX = 6'd16;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SPACE  = 3'd1,
    PH_SIGNED = 3'd2,
    PH_ZERO   = 3'd3,
    PH_PREFIX = 3'd4,
    PH_DIGITS = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    MARK_NONE   = 2'd0,
    MARK_DIGITS = 2'd1,
    MARK_OVF    = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    BSEL_DEC = 2'd0,
    BSEL_OCT = 2'd1,
    BSEL_HEX = 2'd2
  } base_sel_t;

  typedef struct packed {
    logic [7:0]         ch;
    logic               first;
    logic [RADIX_W-1:0] radix;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [OFFSET_W-1:0]          end_offset;
    logic                         overflow;
    logic                         digits_found;
  } out_item_t;

  typedef struct packed {
    logic      start;
    logic      step;
    logic      set_sign;
    logic      set_base;
    base_sel_t base_sel;
    logic      mark_one;
    logic      take;
    logic      close_num;
    logic      emit_prefix;
  } dp_cmd_t;

  typedef struct packed {
    logic is_space;
    logic is_sign;
    logic is_zero;
    logic is_x;
    logic hex_digit;
    logic base_lead0;
    logic term_cur;
    logic term_dec;
    logic term_oct;
  } dp_stat_t;

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd64;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = c - UP_BIAS;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = c - LO_BIAS;
    end
    return d[DIGIT_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/ttip_ctrl.sv
module ttip_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_first,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ttip_pkg::dp_stat_t stat,
  output ttip_pkg::dp_cmd_t  cmd
);
  import ttip_pkg::*;

  phase_t phase_r, phase_nxt, phase_eff;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, emit, lead;

  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign phase_eff = in_first ? PH_SPACE : phase_r;
  assign emit      = cmd.close_num || cmd.emit_prefix;

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.base_sel = BSEL_DEC;
    lead         = 1'b0;
    cmd.start    = accept && in_first;
    if (accept && phase_eff != PH_IDLE) begin
      cmd.step = 1'b1;
      case (phase_eff)
        PH_SPACE: begin
          if (stat.is_sign) begin
            cmd.set_sign = 1'b1;
          end else if (!stat.is_space) begin
            lead = 1'b1;
          end
        end
        PH_SIGNED: begin
          lead = 1'b1;
        end
        PH_ZERO: begin
          cmd.set_base = 1'b1;
          if (stat.is_x) begin
            cmd.base_sel = BSEL_HEX;
          end else begin
            cmd.base_sel  = BSEL_OCT;
            cmd.mark_one  = 1'b1;
            cmd.take      = 1'b1;
            cmd.close_num = stat.term_oct;
          end
        end
        PH_PREFIX: begin
          if (stat.hex_digit) begin
            cmd.take      = 1'b1;
            cmd.close_num = stat.term_cur;
          end else begin
            cmd.emit_prefix = 1'b1;
          end
        end
        PH_DIGITS: begin
          cmd.take      = 1'b1;
          cmd.close_num = stat.term_cur;
        end
        default: begin
          cmd.step = 1'b0;
        end
      endcase
      if (lead && !(stat.is_zero && stat.base_lead0)) begin
        cmd.set_base  = 1'b1;
        cmd.base_sel  = BSEL_DEC;
        cmd.take      = 1'b1;
        cmd.close_num = stat.term_dec;
      end
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      case (phase_eff)
        PH_SPACE: begin
          if (stat.is_sign) begin
            phase_nxt = PH_SIGNED;
          end else if (stat.is_space) begin
            phase_nxt = PH_SPACE;
          end else if (stat.is_zero && stat.base_lead0) begin
            phase_nxt = PH_ZERO;
          end else begin
            phase_nxt = PH_DIGITS;
          end
        end
        PH_SIGNED: begin
          if (stat.is_zero && stat.base_lead0) begin
            phase_nxt = PH_ZERO;
          end else begin
            phase_nxt = PH_DIGITS;
          end
        end
        PH_ZERO: begin
          phase_nxt = stat.is_x ? PH_PREFIX : PH_DIGITS;
        end
        PH_PREFIX: begin
          phase_nxt = PH_DIGITS;
        end
        PH_DIGITS: begin
          phase_nxt = PH_DIGITS;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
      if (emit) begin
        phase_nxt = PH_IDLE;
      end
    end
    out_valid_nxt = (out_valid_r && !out_ready) || (accept && emit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_rose_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(accept))
    else $error("result appeared without an accepted request");

  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_first && phase_r == PH_IDLE |=> !out_valid_r)
    else $error("idle request produced a result");

  a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && emit |=> phase_r == PH_IDLE && out_valid_r)
    else $error("result emitted without returning to idle");
`endif

endmodule

FILE: hw/rtl/ttip_dp.sv
module ttip_dp #(
  parameter int MAX_OFFSET = ttip_pkg::MAX_OFFSET
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ttip_pkg::in_item_t  in_data,
  input  ttip_pkg::dp_cmd_t   cmd,
  output ttip_pkg::dp_stat_t  stat,
  output ttip_pkg::out_item_t out_data
);
  import ttip_pkg::*;

  localparam int VB    = VALUE_BITS;
  localparam int CW    = $clog2(MAX_OFFSET + 1);
  localparam int EXT_W = (CW > OFFSET_W) ? CW : OFFSET_W;
  localparam int NB    = 1 << RADIX_W;
  localparam logic [VB-1:0] LIM_POS = {1'b0, {(VB-1){1'b1}}};
  localparam logic [VB-1:0] LIM_NEG = {1'b1, {(VB-1){1'b0}}};

  // per-base cutoff tables
  logic [VB-1:0]      cutv_pos_tab [NB];
  logic [VB-1:0]      cutv_neg_tab [NB];
  logic [RADIX_W-1:0] cutd_pos_tab [NB];
  logic [RADIX_W-1:0] cutd_neg_tab [NB];

  for (genvar b = 0; b < NB; b++) begin : g_cut
    localparam int DIV = (b == 0) ? 10 : b;
    localparam logic [VB-1:0] QP = LIM_POS / DIV;
    localparam logic [VB-1:0] RP = LIM_POS % DIV;
    localparam logic [VB-1:0] QN = LIM_NEG / DIV;
    localparam logic [VB-1:0] RN = LIM_NEG % DIV;
    assign cutv_pos_tab[b] = QP;
    assign cutd_pos_tab[b] = RP[RADIX_W-1:0];
    assign cutv_neg_tab[b] = QN;
    assign cutd_neg_tab[b] = RN[RADIX_W-1:0];
  end

  logic               neg_r, neg_nxt, neg_cur;
  logic [RADIX_W-1:0] base_r, base_nxt, base_cur, base_new, base_look;
  logic [VB-1:0]      accum_r, accum_nxt, accum_cur, accum_in;
  mark_t              mark_r, mark_nxt, mark_cur, mark_in;
  logic [CW-1:0]      count_r, count_nxt, count_cur;
  logic [VB-1:0]      cutv_r, cutv_nxt;
  logic [RADIX_W-1:0] cutd_r, cutd_nxt;
  out_item_t          out_r, out_nxt;

  logic [DIGIT_W-1:0] dig;
  logic [VB+5:0]      prod;
  logic [VB+5:0]      sum;
  logic               ovf_hit;
  logic [EXT_W-1:0]   idx_ext, idx_m1_ext;
  logic [7:0]         c;

  assign c         = in_data.ch;
  assign dig       = digit_of(c);
  assign neg_cur   = cmd.start ? 1'b0 : neg_r;
  assign base_cur  = cmd.start ? in_data.radix : base_r;
  assign base_look = in_data.first ? in_data.radix : base_r;
  assign accum_cur = cmd.start ? '0 : accum_r;
  assign mark_cur  = cmd.start ? MARK_NONE : mark_r;
  assign count_cur = cmd.start ? '0 : count_r;

  always_comb begin
    base_new = base_cur;
    if (cmd.set_base) begin
      if (cmd.base_sel == BSEL_HEX) begin
        base_new = BASE_HEX;
      end else if (base_cur == '0) begin
        base_new = (cmd.base_sel == BSEL_OCT) ? BASE_OCT : BASE_DEC;
      end
    end
  end

  assign mark_in  = cmd.mark_one ? MARK_DIGITS : mark_cur;
  assign accum_in = cmd.mark_one ? '0 : accum_cur;

  always_comb begin
    stat            = '0;
    stat.is_space   = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    stat.is_sign    = (c == CH_PLUS) || (c == CH_MINUS);
    stat.is_zero    = (c == CH_ZERO);
    stat.is_x       = (c == CH_LO_X) || (c == CH_UP_X);
    stat.hex_digit  = dig < DIGIT_W'(16);
    stat.base_lead0 = (base_look == '0) || (base_look == BASE_HEX);
    stat.term_cur   = dig >= {1'b0, base_look};
    stat.term_dec   = dig >= {1'b0, (base_look == '0) ? BASE_DEC : base_look};
    stat.term_oct   = dig >= {1'b0, (base_look == '0) ? BASE_OCT : base_look};
  end

  // the cycle that picks the base always starts from a zero accumulator
  assign ovf_hit = (mark_in == MARK_OVF) ||
                   (!cmd.set_base && ((accum_in > cutv_r) ||
                                      (accum_in == cutv_r && dig > {1'b0, cutd_r})));
  assign prod = (VB+6)'(accum_in) * (VB+6)'(base_new);
  assign sum  = prod + (VB+6)'(dig);

  assign idx_ext    = EXT_W'(count_cur);
  assign idx_m1_ext = (count_cur == '0) ? '0 : EXT_W'(count_cur - CW'(1));

  always_comb begin
    neg_nxt   = cmd.set_sign ? (c == CH_MINUS) : neg_cur;
    base_nxt  = base_new;
    accum_nxt = accum_in;
    mark_nxt  = mark_in;
    count_nxt = (count_cur < CW'(MAX_OFFSET)) ? count_cur + CW'(1) : count_cur;
    cutv_nxt  = cutv_r;
    cutd_nxt  = cutd_r;
    if (cmd.set_base) begin
      cutv_nxt = neg_cur ? cutv_neg_tab[base_new] : cutv_pos_tab[base_new];
      cutd_nxt = neg_cur ? cutd_neg_tab[base_new] : cutd_pos_tab[base_new];
    end
    if (cmd.take && !cmd.close_num) begin
      if (ovf_hit) begin
        mark_nxt = MARK_OVF;
      end else begin
        mark_nxt  = MARK_DIGITS;
        accum_nxt = sum[VB-1:0];
      end
    end

    out_nxt = out_r;
    if (cmd.emit_prefix) begin
      out_nxt.value        = '0;
      out_nxt.end_offset   = idx_m1_ext[OFFSET_W-1:0];
      out_nxt.overflow     = 1'b0;
      out_nxt.digits_found = 1'b1;
    end else if (cmd.close_num) begin
      case (mark_in)
        MARK_OVF: begin
          out_nxt.value        = neg_cur ? LIM_NEG : LIM_POS;
          out_nxt.end_offset   = idx_ext[OFFSET_W-1:0];
          out_nxt.overflow     = 1'b1;
          out_nxt.digits_found = 1'b1;
        end
        MARK_DIGITS: begin
          out_nxt.value        = neg_cur ? ('0 - accum_in) : accum_in;
          out_nxt.end_offset   = idx_ext[OFFSET_W-1:0];
          out_nxt.overflow     = 1'b0;
          out_nxt.digits_found = 1'b1;
        end
        default: begin
          out_nxt.value        = '0;
          out_nxt.end_offset   = '0;
          out_nxt.overflow     = 1'b0;
          out_nxt.digits_found = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r   <= 1'b0;
      base_r  <= '0;
      accum_r <= '0;
      mark_r  <= MARK_NONE;
      count_r <= '0;
      cutv_r  <= '0;
      cutd_r  <= '0;
    end else if (cmd.step) begin
      neg_r   <= neg_nxt;
      base_r  <= base_nxt;
      accum_r <= accum_nxt;
      mark_r  <= mark_nxt;
      count_r <= count_nxt;
      cutv_r  <= cutv_nxt;
      cutd_r  <= cutd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

FILE: hw/rtl/text_to_integer_parser_unit.sv
// channel  ports                          payload
// in       in_valid / in_ready / in_data  ch, first, radix
// out      out_valid / out_ready / out_data  value, end_offset, overflow, digits_found
//
// one character per cycle when not stalled; a terminating character loads the
// result register in the same cycle it is accepted; the result shows next cycle
// the single output register sets the rate: a request is taken whenever it is
// empty or being drained, and stalls only while a result waits on out_ready
// synchronous active-low reset returns the parser to idle with no result pending
module text_to_integer_parser_unit #(
  parameter int MAX_OFFSET = ttip_pkg::MAX_OFFSET
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ttip_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ttip_pkg::out_item_t out_data
);
  import ttip_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ttip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_first  (in_data.first),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ttip_dp #(
    .MAX_OFFSET (MAX_OFFSET)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

FILE: tb/sv/text_to_integer_parser_unit_tb.sv
`timescale 1ns / 100ps

module text_to_integer_parser_unit_tb;
  import ttip_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_LIMIT = 10000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  text_to_integer_parser_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  out_item_t due_numbers[$];
  bit        steady = 1'b0;
  int        mismatches = 0;
  int        n_strings = 0;
  int        n_chars = 0;
  int        n_results = 0;
  int        n_saturated = 0;
  int        stall_cycles = 0;

  // parser state mirror
  phase_t      p_phase = PH_IDLE;
  logic        p_neg = 1'b0;
  logic [5:0]  p_base = '0;
  logic [31:0] p_acc = '0;
  mark_t       p_mark = MARK_NONE;
  logic [9:0]  p_count = '0;
  logic [31:0] p_cut_val = '0;
  logic [5:0]  p_cut_dig = '0;

  function automatic void clear_parser();
    p_phase = PH_IDLE;
    p_neg = 1'b0;
    p_base = '0;
    p_acc = '0;
    p_mark = MARK_NONE;
    p_count = '0;
    p_cut_val = '0;
    p_cut_dig = '0;
  endfunction

  function automatic logic [6:0] char_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return 7'(c - CH_ZERO);
    if (c >= CH_UP_A && c <= CH_UP_Z) return 7'(c - CH_UP_A + 8'd10);
    if (c >= CH_LO_A && c <= CH_LO_Z) return 7'(c - CH_LO_A + 8'd10);
    return NO_DIGIT;
  endfunction

  function automatic void select_base(input logic [5:0] b);
    longint unsigned lim;
    lim = p_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (b == 0) b = BASE_DEC;
    p_base = b;
    p_cut_val = 32'(lim / b);
    p_cut_dig = 6'(lim % b);
  endfunction

  function automatic void close_number(output out_item_t r, input logic [31:0] v,
                                       input logic [9:0] e, input logic o, input logic d);
    r.value = v;
    r.end_offset = e;
    r.overflow = o;
    r.digits_found = d;
    p_phase = PH_IDLE;
  endfunction

  function automatic bit take_digit(input logic [7:0] c, input logic [9:0] idx,
                                    output out_item_t r);
    logic [6:0] v;
    r = '0;
    v = char_value(c);
    if (v >= {1'b0, p_base}) begin
      case (p_mark)
        MARK_OVF:    close_number(r, p_neg ? 32'h8000_0000 : 32'h7FFF_FFFF, idx, 1'b1, 1'b1);
        MARK_DIGITS: close_number(r, p_neg ? 32'(0 - p_acc) : p_acc, idx, 1'b0, 1'b1);
        default:     close_number(r, '0, '0, 1'b0, 1'b0);
      endcase
      return 1'b1;
    end
    if (p_mark == MARK_OVF || p_acc > p_cut_val || (p_acc == p_cut_val && v > p_cut_dig)) begin
      p_mark = MARK_OVF;
    end else begin
      p_mark = MARK_DIGITS;
      p_acc = 32'(p_acc * p_base + v);
    end
    return 1'b0;
  endfunction

  function automatic bit lead_char(input logic [7:0] c, input logic [9:0] idx,
                                   output out_item_t r);
    r = '0;
    if (c == CH_ZERO && (p_base == 0 || p_base == BASE_HEX)) begin
      p_phase = PH_ZERO;
      return 1'b0;
    end
    select_base(p_base == 0 ? BASE_DEC : p_base);
    p_phase = PH_DIGITS;
    return take_digit(c, idx, r);
  endfunction

  function automatic bit parse_char(input in_item_t it, output out_item_t r);
    logic [9:0] idx;
    r = '0;
    if (it.first) begin
      clear_parser();
      p_base = it.radix;
      p_phase = PH_SPACE;
    end
    if (p_phase == PH_IDLE) return 1'b0;
    idx = p_count;
    if (p_count < MAX_OFFSET) p_count = p_count + 1'b1;
    case (p_phase)
      PH_SPACE: begin
        if (it.ch == CH_SPACE || (it.ch >= CH_TAB && it.ch <= CH_CR)) return 1'b0;
        if (it.ch == CH_MINUS || it.ch == CH_PLUS) begin
          p_neg = (it.ch == CH_MINUS);
          p_phase = PH_SIGNED;
          return 1'b0;
        end
        return lead_char(it.ch, idx, r);
      end
      PH_SIGNED: return lead_char(it.ch, idx, r);
      PH_ZERO: begin
        if (it.ch == CH_LO_X || it.ch == CH_UP_X) begin
          select_base(BASE_HEX);
          p_phase = PH_PREFIX;
          return 1'b0;
        end
        select_base(p_base == 0 ? BASE_OCT : p_base);
        p_acc = '0;
        p_mark = MARK_DIGITS;
        p_phase = PH_DIGITS;
        return take_digit(it.ch, idx, r);
      end
      PH_PREFIX: begin
        if (char_value(it.ch) < 16) begin
          p_phase = PH_DIGITS;
          return take_digit(it.ch, idx, r);
        end
        close_number(r, '0, idx > 0 ? idx - 1'b1 : '0, 1'b0, 1'b1);
        return 1'b1;
      end
      PH_DIGITS: return take_digit(it.ch, idx, r);
      default: begin
        p_phase = PH_IDLE;
        return 1'b0;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic send_char(input in_item_t it);
    out_item_t r;
    if (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_chars++;
    if (parse_char(it, r)) due_numbers.push_back(r);
  endtask

  task automatic send_string(input logic [5:0] rdx, input byte unsigned s[$]);
    in_item_t it;
    n_strings++;
    for (int i = 0; i < s.size(); i++) begin
      it.ch = s[i];
      it.first = (i == 0);
      it.radix = (i == 0) ? rdx : 6'($urandom_range(63));
      send_char(it);
    end
  endtask

  task automatic send_text(input logic [5:0] rdx, input string txt, input bit add_nul);
    byte unsigned s[$];
    for (int i = 0; i < txt.len(); i++) s.push_back(txt[i]);
    if (add_nul) s.push_back(8'h00);
    send_string(rdx, s);
  endtask

  task automatic note_mismatch(input string what, input out_item_t want, input out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected value %0d end %0d ovf %0b dig %0b, got value %0d end %0d ovf %0b dig %0b",
               what, want.value, want.end_offset, want.overflow, want.digits_found,
               got.value, got.end_offset, got.overflow, got.digits_found);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_ready <= steady || ($urandom_range(99) >= 30);
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (out_data.overflow) n_saturated++;
      if (due_numbers.size() == 0) begin
        note_mismatch("unexpected result", '0, out_data);
      end else begin
        want = due_numbers.pop_front();
        if (out_data.value !== want.value || out_data.end_offset !== want.end_offset ||
            out_data.overflow !== want.overflow ||
            out_data.digits_found !== want.digits_found) begin
          note_mismatch("result mismatch", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("no request or result moved for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic test_prefix_forms();
    send_text(6'd0, "0xg", 1'b0);
    send_text(6'd0, "-017", 1'b1);
  endtask

  task automatic test_radix_range();
    send_text(6'd36, "Zz.", 1'b0);
    send_text(6'd1, "01", 1'b0);
    send_text(6'd63, "\t+zZ~", 1'b0);
  endtask

  task automatic test_no_digits();
    send_text(BASE_DEC, " -+", 1'b0);
  endtask

  task automatic test_idle_and_restart();
    in_item_t it;
    it = '{ch: 8'h37, first: 1'b0, radix: 6'd63};
    send_char(it);
    it = '{ch: 8'h35, first: 1'b1, radix: BASE_DEC};
    send_char(it);
    it = '{ch: 8'hFF, first: 1'b1, radix: BASE_DEC};
    send_char(it);
  endtask

  task automatic make_string(output logic [5:0] rdx, output byte unsigned s[$],
                             output int junk);
    int    b;
    int    d;
    int    n;
    string lim_txt;
    s = {};
    junk = 0;
    case ($urandom_range(9))
      0, 1, 2: rdx = 6'd0;
      3:       rdx = BASE_OCT;
      4:       rdx = BASE_DEC;
      5:       rdx = BASE_HEX;
      6:       rdx = 6'd2;
      7:       rdx = 6'd36;
      8:       rdx = 6'd1;
      default: rdx = 6'($urandom_range(63));
    endcase
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(0, 2)) s.push_back($urandom_range(1) ? CH_SPACE :
                                              8'($urandom_range(9, 13)));
    case ($urandom_range(2))
      1:       s.push_back(CH_PLUS);
      2:       s.push_back(CH_MINUS);
      default: ;
    endcase
    b = rdx;
    if ((rdx == 0 || rdx == BASE_HEX) && $urandom_range(2) == 0) begin
      s.push_back(CH_ZERO);
      s.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
      b = 16;
    end else if (rdx == 0) begin
      b = $urandom_range(1) ? 8 : 10;
      if (b == 8) s.push_back(CH_ZERO);
    end
    if (b == 10 && $urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0:       lim_txt = "2147483647";
        1:       lim_txt = "2147483648";
        2:       lim_txt = "2147483649";
        default: lim_txt = "21474836470";
      endcase
      for (int i = 0; i < lim_txt.len(); i++) s.push_back(lim_txt[i]);
    end else begin
      if ($urandom_range(9) == 0) n = 0;
      else if ($urandom_range(3) == 0) n = $urandom_range(8, 40);
      else n = $urandom_range(1, 6);
      repeat (n) begin
        d = $urandom_range((b > 36 ? 36 : b) - 1);
        if (d < 10) s.push_back(8'(CH_ZERO + d));
        else s.push_back(8'(($urandom_range(1) ? CH_LO_A : CH_UP_A) + d - 10));
      end
    end
    case ($urandom_range(7))
      0, 1:    s.push_back(8'h00);
      2:       s.push_back(CH_SPACE);
      3:       s.push_back(8'($urandom_range(128, 255)));
      4:       s.push_back(CH_MINUS);
      5:       s.push_back(8'h2E);
      6:       s.push_back(8'($urandom_range(255)));
      default: ;
    endcase
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        s.push_back(8'($urandom_range(255)));
        junk++;
      end
    end
  endtask

  task automatic test_random_strings(input int count);
    byte unsigned s[$];
    logic [5:0]   rdx;
    int           junk;
    int           sent;
    sent = 0;
    while (sent < count) begin
      steady = (sent > count / 3 && sent < count / 2);
      make_string(rdx, s, junk);
      send_string(rdx, s);
      sent += s.size() - junk;
    end
    steady = 1'b0;
  endtask

  task automatic test_offset_saturation();
    byte unsigned s[$];
    s = {};
    repeat (1025) s.push_back(CH_SPACE);
    s.push_back(CH_ZERO);
    s.push_back(CH_LO_X);
    s.push_back(CH_MINUS);
    send_string(6'd0, s);
  endtask

  initial begin
    int waited;
    clear_parser();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_prefix_forms();
    test_radix_range();
    test_no_digits();
    test_idle_and_restart();
    test_random_strings(350);
    test_offset_saturation();
    in_valid <= 1'b0;
    waited = 0;
    while (due_numbers.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (due_numbers.size() != 0) begin
      $display("%0d expected results never arrived", due_numbers.size());
      mismatches += due_numbers.size();
    end
    $display("parsed %0d strings from %0d characters in bases 0 to 63", n_strings, n_chars);
    $display("checked %0d results, %0d of them saturated, %0d mismatches",
             n_results, n_saturated, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: text_to_integer_parser_unit.f
hw/rtl/ttip_pkg.sv
hw/rtl/ttip_ctrl.sv
hw/rtl/ttip_dp.sv
hw/rtl/text_to_integer_parser_unit.sv
tb/sv/text_to_integer_parser_unit_tb.sv
